/* hw/rtl/sump_cp_pkg.sv */
// ----------------------------------------------------------------------------
// sump_cp_pkg
// Shared types, opcodes and reply tables for the sump command parser.
// ----------------------------------------------------------------------------
package sump_cp_pkg;

  localparam logic [31:0] MEMORY_BYTES     = 32'd4096;
  localparam logic [31:0] MAX_RATE_HZ      = 32'd1000000;
  localparam logic [7:0]  PROBES           = 8'd5;
  localparam logic [26:0] BASE_CLOCK_HZ    = 27'd100000000;
  localparam logic [7:0]  PROTOCOL_VERSION = 8'd2;

  localparam int VALUE_W = 27;
  localparam int PRM_W   = 24;

  // host opcodes
  localparam logic [7:0] OP_RESET = 8'h00;
  localparam logic [7:0] OP_RUN   = 8'h01;
  localparam logic [7:0] OP_ID    = 8'h02;
  localparam logic [7:0] OP_DESC  = 8'h04;
  localparam logic [7:0] OP_XON   = 8'h11;
  localparam logic [7:0] OP_XOFF  = 8'h13;
  localparam logic [7:0] OP_DIV   = 8'h80;
  localparam logic [7:0] OP_CNT   = 8'h81;
  localparam logic [7:0] OP_TRIG  = 8'hC0;

  // actions handed from front to back
  localparam logic [2:0] ACT_RESET = 3'd0;
  localparam logic [2:0] ACT_RUN   = 3'd1;
  localparam logic [2:0] ACT_ID    = 3'd2;
  localparam logic [2:0] ACT_DESC  = 3'd3;
  localparam logic [2:0] ACT_TRIG  = 3'd4;
  localparam logic [2:0] ACT_CNT   = 3'd5;
  localparam logic [2:0] ACT_DIV   = 3'd6;

  // result kinds
  localparam logic [2:0] KIND_REPLY = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_ARM   = 3'd2;
  localparam logic [2:0] KIND_TRIG  = 3'd3;
  localparam logic [2:0] KIND_CNT   = 3'd4;
  localparam logic [2:0] KIND_RATE  = 3'd5;

  // reply table layout: id string, then the metadata record
  localparam logic [4:0] ID_START   = 5'd0;
  localparam logic [4:0] ID_LAST    = 5'd3;
  localparam logic [4:0] DESC_START = 5'd4;
  localparam logic [4:0] DESC_LAST  = 5'd24;

  typedef struct packed {
    logic [2:0]       act;
    logic [PRM_W-1:0] prm;
  } cmd_t;

  function automatic logic [7:0] reply_rom(input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      5'd0:  b = 8'h31;
      5'd1:  b = 8'h41;
      5'd2:  b = 8'h4C;
      5'd3:  b = 8'h53;
      5'd4:  b = 8'h01;
      5'd5:  b = 8'h41;
      5'd6:  b = 8'h54;
      5'd7:  b = 8'h33;
      5'd8:  b = 8'h32;
      5'd9:  b = 8'h00;
      5'd10: b = 8'h21;
      5'd11: b = MEMORY_BYTES[31:24];
      5'd12: b = MEMORY_BYTES[23:16];
      5'd13: b = MEMORY_BYTES[15:8];
      5'd14: b = MEMORY_BYTES[7:0];
      5'd15: b = 8'h23;
      5'd16: b = MAX_RATE_HZ[31:24];
      5'd17: b = MAX_RATE_HZ[23:16];
      5'd18: b = MAX_RATE_HZ[15:8];
      5'd19: b = MAX_RATE_HZ[7:0];
      5'd20: b = 8'h40;
      5'd21: b = PROBES;
      5'd22: b = 8'h41;
      5'd23: b = PROTOCOL_VERSION;
      5'd24: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/sump_command_parser.sv */
// ----------------------------------------------------------------------------
// sump_command_parser
// Host command decoder for a sump-style logic analyzer link.
// ----------------------------------------------------------------------------
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+--------------
//  in      | in_valid, in_stall, in_rx_byte                   | host bytes in
//  out     | out_valid, out_stall, out_kind, out_reply_byte,  | results out
//          | out_value, out_last                              |
//
// a host byte is taken while the four-entry action queue has room
// reset, arm, trigger and count results load in the cycle their action leaves the queue
// id string and metadata record follow in ST_SEQ, one byte a cycle unless stalled (4 and 21 bytes)
// divider: takes the action, runs restoring division in ST_DIV, then loads the rate
// reset clears the front phase, the queue pointers and the back state; no clearing pass
// out_stall holds the result register; the queue lets the front keep taking bytes
// ----------------------------------------------------------------------------
module sump_command_parser import sump_cp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_reply_byte,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  sump_cp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  sump_cp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sump_cp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_reply_byte (out_reply_byte),
    .out_value      (out_value),
    .out_last       (out_last)
  );

endmodule

/* hw/rtl/sump_cp_front.sv */
// ----------------------------------------------------------------------------
// sump_cp_front
// Takes host bytes, gathers long commands and queues the actions they call for.
// ----------------------------------------------------------------------------
module sump_cp_front import sump_cp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic             phase_r, phase_nxt;
  logic [1:0]       pcnt_r, pcnt_nxt;
  logic [7:0]       opc_r, opc_nxt;
  logic [PRM_W-1:0] prm_r, prm_nxt;
  logic             acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    opc_nxt   = opc_r;
    prm_nxt   = prm_r;
    q_push    = 1'b0;
    q_cmd.act = ACT_RESET;
    q_cmd.prm = prm_r;
    if (acc) begin
      if (!phase_r) begin
        unique case (in_rx_byte)
          OP_RESET: begin
            q_push    = 1'b1;
            q_cmd.act = ACT_RESET;
          end
          OP_RUN: begin
            q_push    = 1'b1;
            q_cmd.act = ACT_RUN;
          end
          OP_ID: begin
            q_push    = 1'b1;
            q_cmd.act = ACT_ID;
          end
          OP_DESC: begin
            q_push    = 1'b1;
            q_cmd.act = ACT_DESC;
          end
          OP_XON, OP_XOFF: ;
          default: begin
            opc_nxt   = in_rx_byte;
            pcnt_nxt  = 2'd0;
            phase_nxt = 1'b1;
          end
        endcase
      end else begin
        pcnt_nxt = pcnt_r + 2'd1;
        // b1..b3 are kept, b4 is never used
        unique case (pcnt_r)
          2'd0: prm_nxt[7:0]   = in_rx_byte;
          2'd1: prm_nxt[15:8]  = in_rx_byte;
          2'd2: prm_nxt[23:16] = in_rx_byte;
          2'd3: begin
            phase_nxt = 1'b0;
            unique case (opc_r)
              OP_TRIG: begin
                q_push    = 1'b1;
                q_cmd.act = ACT_TRIG;
              end
              OP_CNT: begin
                q_push    = 1'b1;
                q_cmd.act = ACT_CNT;
              end
              OP_DIV: begin
                q_push    = 1'b1;
                q_cmd.act = ACT_DIV;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      pcnt_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      pcnt_r  <= pcnt_nxt;
    end
    opc_r <= opc_nxt;
    prm_r <= prm_nxt;
  end

endmodule

/* hw/rtl/sump_cp_fifo.sv */
// ----------------------------------------------------------------------------
// sump_cp_fifo
// Four-entry action queue between the byte front end and the reply engine.
// ----------------------------------------------------------------------------
module sump_cp_fifo import sump_cp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

endmodule

/* hw/rtl/sump_cp_back.sv */
// ----------------------------------------------------------------------------
// sump_cp_back
// Carries out queued actions: reply strings, values and the rate divider.
// ----------------------------------------------------------------------------
module sump_cp_back import sump_cp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_reply_byte,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEQ  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam int         DVS_W     = PRM_W + 1;
  localparam logic [4:0] DIV_STEPS = 5'(VALUE_W);

  logic [1:0]         st_r, st_nxt;
  logic [4:0]         idx_r, idx_nxt;
  logic [4:0]         end_r, end_nxt;
  logic [VALUE_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;

  logic               ov_r, ov_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [7:0]         rb_r, rb_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               last_r, last_nxt;

  logic               load_ok;
  logic [DVS_W:0]     rem_sh;
  logic               ge;
  logic [16:0]        cnt_sum;
  logic [VALUE_W-1:0] cnt_val;

  assign load_ok = !ov_r || !out_stall;
  assign rem_sh  = {rem_r, dvd_r[VALUE_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign cnt_sum = {1'b0, q_cmd.prm[15:0]} + 17'd1;
  assign cnt_val = {8'd0, cnt_sum, 2'b00};

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    end_nxt  = end_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    dcnt_nxt = dcnt_r;
    ov_nxt   = ov_r && out_stall;
    kind_nxt = kind_r;
    rb_nxt   = rb_r;
    val_nxt  = val_r;
    last_nxt = last_r;
    q_pop    = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty && load_ok) begin
          q_pop    = 1'b1;
          rb_nxt   = 8'd0;
          val_nxt  = '0;
          last_nxt = 1'b1;
          case (q_cmd.act)
            ACT_RESET: begin
              ov_nxt   = 1'b1;
              kind_nxt = KIND_RESET;
            end
            ACT_RUN: begin
              ov_nxt   = 1'b1;
              kind_nxt = KIND_ARM;
            end
            ACT_ID: begin
              idx_nxt = ID_START;
              end_nxt = ID_LAST;
              st_nxt  = ST_SEQ;
            end
            ACT_DESC: begin
              idx_nxt = DESC_START;
              end_nxt = DESC_LAST;
              st_nxt  = ST_SEQ;
            end
            ACT_TRIG: begin
              ov_nxt   = 1'b1;
              kind_nxt = KIND_TRIG;
              val_nxt  = {19'd0, q_cmd.prm[7:0]};
            end
            ACT_CNT: begin
              ov_nxt   = 1'b1;
              kind_nxt = KIND_CNT;
              val_nxt  = (cnt_val > MEMORY_BYTES[VALUE_W-1:0]) ?
                         MEMORY_BYTES[VALUE_W-1:0] : cnt_val;
            end
            ACT_DIV: begin
              dvd_nxt  = BASE_CLOCK_HZ;
              dvs_nxt  = {1'b0, q_cmd.prm} + DVS_W'(1);
              rem_nxt  = '0;
              dcnt_nxt = DIV_STEPS;
              st_nxt   = ST_DIV;
            end
            default: ;
          endcase
        end
      end
      ST_SEQ: begin
        if (load_ok) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_REPLY;
          rb_nxt   = reply_rom(idx_r);
          val_nxt  = '0;
          last_nxt = (idx_r == end_r);
          idx_nxt  = idx_r + 5'd1;
          if (idx_r == end_r) st_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (dcnt_r != 5'd0) begin
          // restoring division, quotient bits shift in behind the dividend
          rem_nxt  = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
          dvd_nxt  = {dvd_r[VALUE_W-2:0], ge};
          dcnt_nxt = dcnt_r - 5'd1;
        end else if (load_ok) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_RATE;
          rb_nxt   = 8'd0;
          val_nxt  = dvd_r;
          last_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    kind_r <= kind_nxt;
    rb_r   <= rb_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = kind_r;
  assign out_reply_byte = rb_r;
  assign out_value      = val_r;
  assign out_last       = last_r;

endmodule

/* hw/rtl/sump_cp_checker.sv */
// ----------------------------------------------------------------------------
// sump_cp_checker
// Port-level checks on the input and result channels of the command parser.
// ----------------------------------------------------------------------------
module sump_cp_checker import sump_cp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_rx_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_kind,
  input logic [7:0]         out_reply_byte,
  input logic [VALUE_W-1:0] out_value,
  input logic               out_last
);

  // a stalled host byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled host byte changed");

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_reply_byte) && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // every action other than a reply byte is the only result of its byte
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REPLY |-> out_last && out_reply_byte == 8'd0)
    else $error("action result not marked last");

  a_noval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REPLY || out_kind == KIND_RESET ||
      out_kind == KIND_ARM) |-> out_value == '0)
    else $error("value set on a valueless result");

  // count never goes past the sample memory
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CNT |->
      out_value <= MEMORY_BYTES[VALUE_W-1:0] && out_value[1:0] == 2'b00)
    else $error("sample count out of range");

endmodule

bind sump_command_parser sump_cp_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_rx_byte     (in_rx_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_reply_byte (out_reply_byte),
  .out_value      (out_value),
  .out_last       (out_last)
);

/* dv/sump_command_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sump_command_parser_tb
// Self-checking bench for the host command parser. Host bytes are queued up
// front (a directed opening, then mostly well-formed random commands mixed
// with truncated commands and noise), driven over valid/stall, and every
// result is checked field by field against a predictor of the protocol.
// ----------------------------------------------------------------------------
module sump_command_parser_tb;
  import sump_cp_pkg::*;

  localparam logic [7:0] OP_FLAGS = 8'h82;

  localparam int TOTAL_ITEMS   = 150;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_AT      = 75;
  localparam int CALM_FROM     = 95;
  localparam int CALM_TO       = 135;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 40;

  localparam logic [31:0] ID_TEXT     = "1ALS";
  localparam logic [47:0] DEVICE_NAME = 48'h01_41_54_33_32_00;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         reply_byte;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       drain;
  } host_item_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [2:0]         out_kind;
  logic [7:0]         out_reply_byte;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;

  host_item_t host_q[$];
  result_t    expected_q[$];
  result_t    staged_q[$];

  // predictor state
  logic       collecting = 1'b0;
  logic [7:0] cmd_op     = 8'h00;
  logic [7:0] cmd_prm [1:4];
  logic [2:0] prm_seen   = 3'd0;

  int   items_taken  = 0;
  int   pred_total   = 0;
  int   seen_total   = 0;
  int   stall_cycles = 0;
  int   cycle_count  = 0;
  int   error_count  = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic calm;

  logic [7:0] short_ops [6] = '{OP_RESET, OP_RUN, OP_ID, OP_DESC, OP_XON, OP_XOFF};

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  sump_command_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_reply_byte (out_reply_byte),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch @%0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  function automatic void stage(input logic [2:0] kind, input logic [7:0] rb,
                                input logic [31:0] val);
    result_t r;
    r.kind       = kind;
    r.reply_byte = rb;
    r.value      = val[VALUE_W-1:0];
    r.last       = 1'b0;
    staged_q.push_back(r);
  endfunction

  // big-endian 32-bit field of the metadata record
  function automatic void stage_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) stage(KIND_REPLY, w[8*i +: 8], 32'd0);
  endfunction

  // returns the number of results this host byte causes, queues them
  function automatic int decode_host_byte(input logic [7:0] b);
    logic [31:0] count;
    logic [31:0] divisor;
    result_t     r;
    int          n;
    staged_q.delete();
    if (!collecting) begin
      case (b)
        OP_RESET: stage(KIND_RESET, 8'd0, 32'd0);
        OP_RUN:   stage(KIND_ARM, 8'd0, 32'd0);
        OP_ID: begin
          for (int i = 3; i >= 0; i--) stage(KIND_REPLY, ID_TEXT[8*i +: 8], 32'd0);
        end
        OP_DESC: begin
          for (int i = 5; i >= 0; i--) stage(KIND_REPLY, DEVICE_NAME[8*i +: 8], 32'd0);
          stage(KIND_REPLY, 8'h21, 32'd0);
          stage_word(MEMORY_BYTES);
          stage(KIND_REPLY, 8'h23, 32'd0);
          stage_word(MAX_RATE_HZ);
          stage(KIND_REPLY, 8'h40, 32'd0);
          stage(KIND_REPLY, PROBES, 32'd0);
          stage(KIND_REPLY, 8'h41, 32'd0);
          stage(KIND_REPLY, PROTOCOL_VERSION, 32'd0);
          stage(KIND_REPLY, 8'h00, 32'd0);
        end
        OP_XON, OP_XOFF: ;
        default: begin
          collecting = 1'b1;
          cmd_op     = b;
          prm_seen   = 3'd0;
        end
      endcase
    end else begin
      // any byte is a parameter here, short opcodes included
      prm_seen          = prm_seen + 3'd1;
      cmd_prm[prm_seen] = b;
      if (prm_seen == 3'd4) begin
        case (cmd_op)
          OP_TRIG: stage(KIND_TRIG, 8'd0, {24'd0, cmd_prm[1]});
          OP_CNT: begin
            count = ({16'd0, cmd_prm[2], cmd_prm[1]} + 32'd1) * 32'd4;
            if (count > MEMORY_BYTES) count = MEMORY_BYTES;
            stage(KIND_CNT, 8'd0, count);
          end
          OP_DIV: begin
            divisor = {8'd0, cmd_prm[3], cmd_prm[2], cmd_prm[1]} + 32'd1;
            stage(KIND_RATE, 8'd0, {5'd0, BASE_CLOCK_HZ} / divisor);
          end
          default: ;
        endcase
        collecting = 1'b0;
        prm_seen   = 3'd0;
      end
    end
    n = staged_q.size();
    for (int i = 0; i < n; i++) begin
      r      = staged_q[i];
      r.last = (i == n - 1);
      expected_q.push_back(r);
    end
    return n;
  endfunction

  function automatic void add_item(input logic [7:0] b);
    host_item_t it;
    it.data  = b;
    it.drain = (host_q.size() == DRAIN_AT);
    host_q.push_back(it);
  endfunction

  function automatic void add_long(input logic [7:0] op, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input logic [7:0] b4);
    add_item(op);
    add_item(b1);
    add_item(b2);
    add_item(b3);
    add_item(b4);
  endfunction

  // host side: one item offered at a time, held until taken
  always @(posedge clk) begin : host_driver
    logic       busy;
    int         n_now;
    host_item_t nxt;
    if (rst_n) begin
      busy  = in_valid && in_stall;
      n_now = 0;
      if (in_valid && !in_stall) begin
        n_now = decode_host_byte(in_rx_byte);
        items_taken <= items_taken + 1;
      end
      pred_total <= pred_total + n_now;
      if (busy) stall_cycles <= stall_cycles + 1;
      if (!busy) begin
        if (host_q.size() != 0 &&
            !(host_q[0].drain && (pred_total + n_now != seen_total)) &&
            (calm || $urandom_range(99) >= 7)) begin
          nxt = host_q.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && items_taken >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen_total <= seen_total + 1;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d byte 0x%02h value %0d last %0b",
                                  out_kind, out_reply_byte, out_value, out_last));
      end else begin
        want = expected_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("item %0d kind %0d, want %0d",
                                    seen_total, out_kind, want.kind));
        if (out_reply_byte !== want.reply_byte)
          report_mismatch($sformatf("item %0d reply_byte 0x%02h, want 0x%02h",
                                    seen_total, out_reply_byte, want.reply_byte));
        if (out_value !== want.value)
          report_mismatch($sformatf("item %0d value %0d, want %0d",
                                    seen_total, out_value, want.value));
        if (out_last !== want.last)
          report_mismatch($sformatf("item %0d last %0b, want %0b",
                                    seen_total, out_last, want.last));
      end
    end
  end

  initial begin
    int         pick;
    int         n_items;
    logic [7:0] op;
    logic [7:0] b1, b2, b3, b4;

    // directed opening: every short opcode, then long commands at their edges
    foreach (short_ops[i]) add_item(short_ops[i]);
    add_long(OP_TRIG, OP_ID, OP_DESC, OP_XON, OP_XOFF);
    add_long(OP_CNT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_long(OP_DIV, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_long(OP_DIV, 8'h00, 8'h00, 8'h00, 8'h00);

    while (host_q.size() < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        add_item(short_ops[3'($urandom_range(5))]);
      end else if (pick < 85) begin
        case ($urandom_range(4))
          0: op = OP_TRIG;
          1: op = OP_CNT;
          2: op = OP_DIV;
          3: op = OP_FLAGS;
          default: op = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h83))
                                           : 8'($urandom_range(8'hFF, 8'hC1));
        endcase
        b1 = 8'($urandom_range(255));
        b2 = 8'($urandom_range(255));
        b3 = 8'($urandom_range(255));
        b4 = 8'($urandom_range(255));
        // keep counts near the memory-size clamp
        if (op == OP_CNT && $urandom_range(1) == 1) b2 = 8'($urandom_range(4));
        // small dividers give the high rates
        if (op == OP_DIV && $urandom_range(2) == 0) begin
          b3 = 8'h00;
          if ($urandom_range(1) == 1) b2 = 8'h00;
        end
        add_long(op, b1, b2, b3, b4);
      end else if (pick < 92) begin
        // truncated command, the next bytes get swallowed as parameters
        add_item($urandom_range(1) ? OP_CNT : OP_DIV);
        repeat ($urandom_range(3)) add_item(8'($urandom_range(255)));
      end else begin
        add_item(8'($urandom_range(255)));
      end
    end
    n_items = host_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < n_items) @(posedge clk);
    while (pred_total != seen_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("covered %0d host bytes, %0d results checked in %0d cycles",
             items_taken, seen_total, cycle_count);
    $display("input held off by the block for %0d cycles under back-pressure",
             stall_cycles);
    if (error_count == 0) begin
      $display("[sump_command_parser] OK");
    end else begin
      $display("[sump_command_parser] ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pred_total - seen_total);
    $display("[sump_command_parser] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sump_cp_pkg.sv
hw/rtl/sump_cp_front.sv
hw/rtl/sump_cp_fifo.sv
hw/rtl/sump_cp_back.sv
hw/rtl/sump_command_parser.sv
hw/rtl/sump_cp_checker.sv
dv/sump_command_parser_tb.sv
